// ===== hdl/hsvd_pkg.sv =====
`default_nettype none
package hsvd_pkg;
   localparam int COUNT_BITS = 21;
   localparam int NUM_REGS = 8;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 10;

   localparam logic [CSR_IDX_BITS-1:0] REG_HUE_LOW = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_HUE_HIGH = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_SAT_LOW = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_SAT_HIGH = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_VAL_LOW = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_VAL_HIGH = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_ZAP_ENABLE = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] REG_THRESHOLD = 3'd7;

   localparam logic [9:0] THRESHOLD_RESET = 10'd100;
   localparam logic [7:0] BLACK_LUMA = 8'd16;
   localparam logic [7:0] BLACK_CHROMA = 8'd128;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
      logic       frame_last;
   } req_type;

   typedef struct packed {
      logic                  match;
      logic                  zapped;
      logic [7:0]            out_luma;
      logic [7:0]            out_chroma_blue;
      logic [7:0]            out_chroma_red;
      logic                  frame_done;
      logic [COUNT_BITS-1:0] match_total;
      logic                  detected;
   } rsp_type;

   typedef struct packed {
      logic [8:0] hue_low;
      logic [8:0] hue_high;
      logic [7:0] sat_low;
      logic [7:0] sat_high;
      logic [7:0] val_low;
      logic [7:0] val_high;
      logic       zap_enable;
      logic [9:0] threshold;
   } cfg_type;

   // classified pixel handed from front to back
   typedef struct packed {
      req_type req;
      logic    match;
   } cls_type;

   function automatic logic [7:0] clamp_channel(input logic signed [22:0] acc);
      logic signed [12:0] q;
      begin
         q = acc[22:10];
         if (acc < 0) clamp_channel = 8'd0;
         else if (q > 13'sd255) clamp_channel = 8'd255;
         else clamp_channel = q[7:0];
      end
   endfunction
endpackage
`default_nettype wire

// ===== hdl/hsvd_divider.sv =====
`default_nettype none
// restoring divider, 16-bit numerator over 8-bit denominator, one bit a cycle
module hsvd_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [15:0] num,
   input  wire logic [7:0]  den,
   output logic             done,
   output logic [15:0]      quot
);
   logic [15:0] q_ff, q_in;
   logic [8:0]  rem_ff, rem_in;
   logic [7:0]  den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [8:0]  trial;

   always_comb begin
      q_in = q_ff; rem_in = rem_ff; den_in = den_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff[7:0], q_ff[15]};
      if (start) begin
         q_in = num; rem_in = 9'd0; den_in = den; cnt_in = 5'd16; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in = {q_ff[14:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; rem_ff <= rem_in; den_ff <= den_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

// ===== hdl/hsvd_front.sv =====
`default_nettype none
// converts and classifies one pixel at a time
module hsvd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire hsvd_pkg::cfg_type  cfg,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire hsvd_pkg::req_type  req_data,
   output logic                    cls_valid,
   input  wire logic               cls_ready,
   output hsvd_pkg::cls_type       cls_data
);
   import hsvd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_RGB, S_HUE_DIV, S_SAT_DIV, S_OUT
   } state_type;

   state_type   state_ff;
   req_type     req_ff;
   logic signed [22:0] yt_ff, cr_r_ff, cb_g_ff, cr_g_ff, cb_b_ff;
   logic [7:0]  mx_ff, mn_ff;
   logic [1:0]  sector_ff;
   logic        neg_ff;
   logic [8:0]  hue_ff;
   logic [7:0]  sat_ff;
   logic        cls_match;
   logic        div_start;
   logic [15:0] div_num;
   logic [7:0]  div_den;
   logic        div_done;
   logic [15:0] div_quot;

   logic [7:0]  r, g, b, mx, mn;
   logic signed [8:0] fs;
   logic [1:0]  sector;
   logic signed [9:0] hue_raw;
   logic [8:0]  hue_fix;
   logic signed [8:0] cb_s, cr_s;

   hsvd_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .done(div_done), .quot(div_quot)
   );

   always_comb begin
      cb_s = $signed({1'b0, req_data.chroma_blue}) - 9'sd128;
      cr_s = $signed({1'b0, req_data.chroma_red}) - 9'sd128;
      r = clamp_channel(yt_ff + cr_r_ff + 23'sd512);
      g = clamp_channel(yt_ff - cb_g_ff - cr_g_ff + 23'sd512);
      b = clamp_channel(yt_ff + cb_b_ff + 23'sd512);
      mn = (r < g) ? r : g;
      if (b < mn) mn = b;
      mx = (r > g) ? r : g;
      if (b > mx) mx = b;
      if (r == mx) begin
         sector = 2'd0; fs = $signed({1'b0, g}) - $signed({1'b0, b});
      end else if (g == mx) begin
         sector = 2'd1; fs = $signed({1'b0, b}) - $signed({1'b0, r});
      end else begin
         sector = 2'd2; fs = $signed({1'b0, r}) - $signed({1'b0, g});
      end
      // truncating division: divide magnitude, then reapply sign
      hue_raw = neg_ff ? -$signed({2'b00, div_quot[7:0]}) : $signed({2'b00, div_quot[7:0]});
      hue_raw = hue_raw + $signed({2'b00, sector_ff, 6'd0} >> 6) * 10'sd120;
      hue_fix = (hue_raw < 0) ? 9'(hue_raw + 10'sd360) : hue_raw[8:0];
      div_start = 1'b0;
      div_num = 16'd0;
      div_den = mx_ff - mn_ff;
      if (state_ff == S_RGB && mx != mn) begin
         div_start = 1'b1;
         div_num = 16'd60 * {8'd0, (fs < 0) ? 8'(-fs) : fs[7:0]};
         div_den = mx - mn;
      end else if (state_ff == S_HUE_DIV && div_done) begin
         div_start = 1'b1;
         div_num = 16'd255 * {8'd0, mx_ff - mn_ff};
         div_den = mx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_push) begin
               req_ff <= req_data;
               yt_ff <= 23'(($signed({1'b0, req_data.luma}) - 10'sd16) * 23'sd1192);
               cr_r_ff <= 23'(cr_s * 23'sd1634);
               cb_g_ff <= 23'(cb_s * 23'sd401);
               cr_g_ff <= 23'(cr_s * 23'sd832);
               cb_b_ff <= 23'(cb_s * 23'sd2066);
               state_ff <= S_RGB;
            end
            S_RGB: begin
               mx_ff <= mx; mn_ff <= mn; sector_ff <= sector; neg_ff <= fs < 0;
               if (mx == mn) begin
                  hue_ff <= 9'd0; sat_ff <= 8'd0; state_ff <= S_OUT;
               end else begin
                  state_ff <= S_HUE_DIV;
               end
            end
            S_HUE_DIV: if (div_done) begin
               hue_ff <= hue_fix; state_ff <= S_SAT_DIV;
            end
            S_SAT_DIV: if (div_done) begin
               sat_ff <= div_quot[7:0]; state_ff <= S_OUT;
            end
            S_OUT: if (cls_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cls_match = hue_ff >= cfg.hue_low && hue_ff <= cfg.hue_high &&
                  sat_ff >= cfg.sat_low && sat_ff <= cfg.sat_high &&
                  mx_ff >= cfg.val_low && mx_ff <= cfg.val_high;
   end

   assign req_full = (state_ff != S_IDLE) || reset;
   assign cls_valid = state_ff == S_OUT;
   assign cls_data = '{req: req_ff, match: cls_match};
endmodule
`default_nettype wire

// ===== hdl/hsvd_back.sv =====
`default_nettype none
// counts, zaps and queues results
module hsvd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire hsvd_pkg::cfg_type  cfg,
   input  wire logic               cls_valid,
   output logic                    cls_ready,
   input  wire hsvd_pkg::cls_type  cls_data,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output hsvd_pkg::rsp_type       rsp_data
);
   import hsvd_pkg::*;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   logic [COUNT_BITS-1:0] match_cnt_ff, pix_cnt_ff, mtot, ptot;
   logic [COUNT_BITS+9:0] lhs_ff, rhs_ff;
   logic                  stage_ff;   // product compare pending
   rsp_type               pend_ff, rsp_ff, rsp_in;
   logic                  rsp_valid_ff;
   logic                  take;
   logic                  stage_move;
   logic                  zap;

   assign cls_ready = !stage_ff;
   assign take = cls_valid && cls_ready;
   assign stage_move = stage_ff && (!rsp_valid_ff || rsp_pop);

   always_comb begin
      mtot = (cls_data.match && match_cnt_ff != CNT_MAX) ?
             match_cnt_ff + COUNT_BITS'(1) : match_cnt_ff;
      ptot = (pix_cnt_ff != CNT_MAX) ? pix_cnt_ff + COUNT_BITS'(1) : pix_cnt_ff;
      zap = !cls_data.match && cfg.zap_enable;
      rsp_in = pend_ff;
      rsp_in.detected = pend_ff.frame_done && lhs_ff >= rhs_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_cnt_ff <= '0; pix_cnt_ff <= '0; stage_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            pend_ff <= '{match: cls_data.match, zapped: zap,
               out_luma: zap ? BLACK_LUMA : cls_data.req.luma,
               out_chroma_blue: zap ? BLACK_CHROMA : cls_data.req.chroma_blue,
               out_chroma_red: zap ? BLACK_CHROMA : cls_data.req.chroma_red,
               frame_done: cls_data.req.frame_last, match_total: mtot, detected: 1'b0};
            lhs_ff <= (COUNT_BITS+10)'(mtot) * (COUNT_BITS+10)'(1000);
            rhs_ff <= (COUNT_BITS+10)'(cfg.threshold) * (COUNT_BITS+10)'(ptot);
            if (cls_data.req.frame_last) begin
               match_cnt_ff <= '0; pix_cnt_ff <= '0;
            end else begin
               match_cnt_ff <= mtot; pix_cnt_ff <= ptot;
            end
         end
         if (stage_move) rsp_ff <= rsp_in;
         stage_ff <= take || (stage_ff && !stage_move);
         rsp_valid_ff <= stage_move || (rsp_valid_ff && !rsp_pop);
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

// ===== hdl/hsv_range_pixel_detector_unit.sv =====
`default_nettype none
// channel   direction  handshake        payload
// req       in         req_push/full    hsvd_pkg::req_type
// rsp       out        rsp_empty/pop    hsvd_pkg::rsp_type
// csr       in         csr_write        index 3b, data 10b
// A colored request passes from acceptance to result through an RGB step, two serial
// divisions (hue, saturation), a hand-off to the back and a back stage.
// Grey pixels skip the divisions. The front accepts the next request the cycle after
// it hands off, and takes no new request while one is still in flight.
// Synchronous reset clears counters, CSRs, state and valid flags. The back holds one
// result plus one staged request; once both wait, the front stalls and req_full stays high.
module hsv_range_pixel_detector_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire hsvd_pkg::req_type               req_data,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output hsvd_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_write,
   input  wire logic [hsvd_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [hsvd_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import hsvd_pkg::*;

   cfg_type cfg_ff;
   logic    cls_valid, cls_ready;
   cls_type cls_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{default: '0, threshold: THRESHOLD_RESET};
      end else if (csr_write) begin
         unique case (csr_index)
            REG_HUE_LOW:    cfg_ff.hue_low <= csr_data[8:0];
            REG_HUE_HIGH:   cfg_ff.hue_high <= csr_data[8:0];
            REG_SAT_LOW:    cfg_ff.sat_low <= csr_data[7:0];
            REG_SAT_HIGH:   cfg_ff.sat_high <= csr_data[7:0];
            REG_VAL_LOW:    cfg_ff.val_low <= csr_data[7:0];
            REG_VAL_HIGH:   cfg_ff.val_high <= csr_data[7:0];
            REG_ZAP_ENABLE: cfg_ff.zap_enable <= csr_data[0];
            REG_THRESHOLD:  cfg_ff.threshold <= csr_data;
            default: ;
         endcase
      end
   end

   hsvd_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .cls_valid(cls_valid), .cls_ready(cls_ready), .cls_data(cls_data)
   );

   hsvd_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .cls_valid(cls_valid), .cls_ready(cls_ready), .cls_data(cls_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

// ===== bench/hsv_pixel_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hsv_pixel_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   input  wire logic                                req_full,
   input  wire hsvd_pkg::req_type                   req_data,
   input  wire logic                                rsp_empty,
   input  wire logic                                rsp_pop,
   input  wire hsvd_pkg::rsp_type                   rsp_data,
   input  wire logic                                csr_write,
   input  wire logic [hsvd_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [hsvd_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                       fail_count,
   output int                                       pending,
   output int                                       rsp_seen,
   output int                                       match_seen,
   output int                                       detect_seen
);
   import hsvd_pkg::*;

   cfg_type cfg;
   logic [COUNT_BITS-1:0] match_cnt, pixel_cnt;
   rsp_type expected_q[$];

   function automatic int to_channel(int acc);
      if (acc < 0) return 0;
      if ((acc >>> 10) > 255) return 255;
      return acc >>> 10;
   endfunction

   task automatic classify_pixel(input req_type px);
      int yt, cb, cr, r, g, b, mx, mn, hue, sat, f, base;
      logic hit;
      logic [COUNT_BITS-1:0] lim;
      rsp_type e;
      lim = '1;
      cb = int'(px.chroma_blue) - 128;
      cr = int'(px.chroma_red) - 128;
      yt = (int'(px.luma) - 16) * 1192;
      r = to_channel(yt + 1634 * cr + 512);
      g = to_channel(yt - 401 * cb - 832 * cr + 512);
      b = to_channel(yt + 2066 * cb + 512);
      mx = r > g ? r : g; if (b > mx) mx = b;
      mn = r < g ? r : g; if (b < mn) mn = b;
      hue = 0; sat = 0;
      if (mx != mn) begin
         if (r == mx) begin f = g - b; base = 0; end
         else if (g == mx) begin f = b - r; base = 120; end
         else begin f = r - g; base = 240; end
         hue = base + (60 * f) / (mx - mn);
         if (hue < 0) hue += 360;
         sat = (255 * (mx - mn)) / mx;
      end
      hit = hue >= cfg.hue_low && hue <= cfg.hue_high && sat >= cfg.sat_low &&
            sat <= cfg.sat_high && mx >= cfg.val_low && mx <= cfg.val_high;
      e = '0;
      e.match = hit;
      e.zapped = !hit && cfg.zap_enable;
      e.out_luma = e.zapped ? BLACK_LUMA : px.luma;
      e.out_chroma_blue = e.zapped ? BLACK_CHROMA : px.chroma_blue;
      e.out_chroma_red = e.zapped ? BLACK_CHROMA : px.chroma_red;
      e.frame_done = px.frame_last;
      if (hit && match_cnt != lim) match_cnt++;
      if (pixel_cnt != lim) pixel_cnt++;
      e.match_total = match_cnt;
      if (px.frame_last) begin
         e.detected = pixel_cnt != 0 &&
            64'(match_cnt) * 1000 >= 64'(cfg.threshold) * 64'(pixel_cnt);
         match_cnt = '0;
         pixel_cnt = '0;
      end
      expected_q.push_back(e);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg <= '{default: '0, threshold: THRESHOLD_RESET};
         match_cnt = '0;
         pixel_cnt = '0;
         expected_q.delete();
         pending <= 0;
         fail_count <= 0; rsp_seen <= 0; match_seen <= 0; detect_seen <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_HUE_LOW:    cfg.hue_low <= csr_data[8:0];
               REG_HUE_HIGH:   cfg.hue_high <= csr_data[8:0];
               REG_SAT_LOW:    cfg.sat_low <= csr_data[7:0];
               REG_SAT_HIGH:   cfg.sat_high <= csr_data[7:0];
               REG_VAL_LOW:    cfg.val_low <= csr_data[7:0];
               REG_VAL_HIGH:   cfg.val_high <= csr_data[7:0];
               REG_ZAP_ENABLE: cfg.zap_enable <= csr_data[0];
               REG_THRESHOLD:  cfg.threshold <= csr_data;
               default: ;
            endcase
         end
         if (req_push && !req_full) classify_pixel(req_data);
         if (rsp_pop && !rsp_empty) begin
            rsp_seen <= rsp_seen + 1;
            if (rsp_data.match) match_seen <= match_seen + 1;
            if (rsp_data.detected) detect_seen <= detect_seen + 1;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else if (rsp_data !== expected_q[0]) begin
               $display("%0t: mismatch expected %p actual %p", $time, expected_q[0],
                        rsp_data);
               fail_count <= fail_count + 1;
               void'(expected_q.pop_front());
            end else
               void'(expected_q.pop_front());
         end
         pending <= expected_q.size();
      end
   end
endmodule
`default_nettype wire

// ===== bench/tb_hsv_range_pixel_detector_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_hsv_range_pixel_detector_unit;
   import hsvd_pkg::*;

   logic clock = 0, reset = 1;
   logic req_push = 0, rsp_pop = 0, csr_write = 0;
   logic req_full, rsp_empty;
   req_type req_data = '0;
   rsp_type rsp_data;
   logic [CSR_IDX_BITS-1:0] csr_index = REG_HUE_LOW;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;
   int fail_count, pending, rsp_seen, match_seen, detect_seen;
   int idle_cycles = 0, hold_off = 0;
   bit long_stall = 0;

   always begin #4 clock = 1; #4 clock = 0; end

   hsv_range_pixel_detector_unit dut (.*);
   hsv_pixel_checker chk (.*);

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("timeout waiting for a handshake");
         $display("FAIL hsv_range_pixel_detector_unit");
         $finish;
      end
   end

   // response side: random pops, one long hold-off on request
   always @(posedge clock) begin
      if (reset) rsp_pop <= 0;
      else if (long_stall && hold_off < 400) begin
         hold_off <= hold_off + 1;
         rsp_pop <= 0;
      end else if ($urandom_range(0, 99) < 3) rsp_pop <= 0;
      else if ($urandom_range(0, 99) < 25) rsp_pop <= 0;
      else rsp_pop <= 1;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // leaves req_push high after the accepting edge; the caller lowers it
   task automatic send_pixel(input req_type px, input bit gaps);
      int n;
      n = gaps ? gap_len() : 0;
      if (n != 0) begin
         req_push <= 0;
         repeat (n) @(posedge clock);
      end
      req_push <= 1;
      req_data <= px;
      do @(posedge clock); while (req_full);
   endtask

   // leaves csr_write high; set_ranges lowers it
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input int val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= CSR_DATA_BITS'(val);
      @(posedge clock);
   endtask

   task automatic drain();
      req_push <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_ranges(input int hl, hh, sl, sh, vl, vh, zap, thr);
      write_reg(REG_HUE_LOW, hl);  write_reg(REG_HUE_HIGH, hh);
      write_reg(REG_SAT_LOW, sl);  write_reg(REG_SAT_HIGH, sh);
      write_reg(REG_VAL_LOW, vl);  write_reg(REG_VAL_HIGH, vh);
      write_reg(REG_ZAP_ENABLE, zap); write_reg(REG_THRESHOLD, thr);
      csr_write <= 0;
   endtask

   task automatic random_frames(input int pixels);
      req_type px;
      int left;
      left = pixels;
      while (left > 0) begin
         px.luma = $urandom;
         px.chroma_blue = $urandom;
         px.chroma_red = $urandom;
         // mostly short frames, occasional grey pixels
         px.frame_last = $urandom_range(0, 11) == 0;
         if ($urandom_range(0, 9) == 0) begin
            px.chroma_blue = BLACK_CHROMA; px.chroma_red = BLACK_CHROMA;
         end
         send_pixel(px, 1);
         left--;
      end
      px.frame_last = 1;
      send_pixel(px, 1);
   endtask

   initial begin
      req_type px;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, grey, full-scale colors, frame ends
      set_ranges(0, 360, 0, 255, 0, 255, 1, 1000);
      send_pixel('{8'd0, 8'd0, 8'd0, 1'b0}, 0);
      send_pixel('{8'd255, 8'd255, 8'd255, 1'b0}, 0);
      send_pixel('{8'd128, 8'd128, 8'd128, 1'b0}, 0);
      send_pixel('{8'd16, 8'd128, 8'd128, 1'b0}, 0);
      send_pixel('{8'd235, 8'd128, 8'd128, 1'b1}, 0);
      send_pixel('{8'd81, 8'd90, 8'd240, 1'b0}, 0);
      send_pixel('{8'd145, 8'd54, 8'd34, 1'b0}, 0);
      send_pixel('{8'd41, 8'd240, 8'd110, 1'b0}, 0);
      send_pixel('{8'd100, 8'd200, 8'd200, 1'b1}, 0);
      drain();
      set_ranges(300, 20, 0, 255, 0, 255, 1, 0);
      send_pixel('{8'd81, 8'd90, 8'd240, 1'b0}, 0);
      send_pixel('{8'd128, 8'd255, 8'd0, 1'b1}, 0);
      drain();
      set_ranges(0, 511, 0, 255, 0, 255, 0, 1023);
      send_pixel('{8'd170, 8'd170, 8'd85, 1'b1}, 0);
      send_pixel('{8'd85, 8'd85, 8'd170, 1'b1}, 0);
      drain();
      // random phases over several range settings
      set_ranges(0, 359, 0, 255, 0, 255, 0, 100);
      random_frames(300);
      drain();
      set_ranges(0, 120, 60, 255, 40, 255, 1, 300);
      long_stall = 1;
      random_frames(400);
      drain();
      set_ranges(180, 300, 0, 128, 100, 200, 1, 50);
      random_frames(400);
      drain();
      set_ranges(90, 270, 20, 200, 10, 240, 0, 500);
      random_frames(400);
      drain();
      set_ranges($urandom_range(0, 360), $urandom_range(0, 360), $urandom_range(0, 255),
                 255, 0, $urandom_range(0, 255), 1, $urandom_range(0, 1000));
      random_frames(400);
      drain();
      $display("%0d responses checked, %0d matches, %0d frames detected",
               rsp_seen, match_seen, detect_seen);
      if (fail_count == 0) $display("PASS hsv_range_pixel_detector_unit");
      else $display("FAIL hsv_range_pixel_detector_unit");
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/hsvd_pkg.sv
hdl/hsvd_divider.sv
hdl/hsvd_front.sv
hdl/hsvd_back.sv
hdl/hsv_range_pixel_detector_unit.sv
bench/hsv_pixel_checker.sv
bench/tb_hsv_range_pixel_detector_unit.sv
